### rtl/core/mbc_pkg.sv
// Package for the Magma 64-bit block cipher core: word types, key schedule
// type, S-box table, round function and key word selection.
// No dependencies.
package mbc_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockW     = 64;
  localparam int unsigned NumRounds  = 32;
  localparam int unsigned NumKeyWords = 8;
  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned RotAmt     = 11;
  localparam int unsigned FwdRounds  = 24;
  localparam logic [2:0]  WordMask   = 3'h7;

  localparam logic KindEncrypt = 1'b0;
  localparam logic KindDecrypt = 1'b1;

  typedef logic [WordW-1:0] word_t;
  typedef logic [0:NumKeyWords-1][WordW-1:0] key_sched_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } stage_ctl_t;

  localparam logic [0:7][0:15][3:0] SBOX = '{
    '{4'h1, 4'h7, 4'he, 4'hd, 4'h0, 4'h5, 4'h8, 4'h3,
      4'h4, 4'hf, 4'ha, 4'h6, 4'h9, 4'hc, 4'hb, 4'h2},
    '{4'h8, 4'he, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hc,
      4'hf, 4'h4, 4'hb, 4'h0, 4'hd, 4'ha, 4'h3, 4'h7},
    '{4'h5, 4'hd, 4'hf, 4'h6, 4'h9, 4'h2, 4'hc, 4'ha,
      4'hb, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'he, 4'h0},
    '{4'h7, 4'hf, 4'h5, 4'ha, 4'h8, 4'h1, 4'h6, 4'hd,
      4'h0, 4'h9, 4'h3, 4'he, 4'hb, 4'h4, 4'h2, 4'hc},
    '{4'hc, 4'h8, 4'h2, 4'h1, 4'hd, 4'h4, 4'hf, 4'h6,
      4'h7, 4'h0, 4'ha, 4'h5, 4'h3, 4'he, 4'h9, 4'hb},
    '{4'hb, 4'h3, 4'h5, 4'h8, 4'h2, 4'hf, 4'ha, 4'hd,
      4'he, 4'h1, 4'h7, 4'h4, 4'hc, 4'h9, 4'h6, 4'h0},
    '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'ha, 4'h5, 4'hc,
      4'h1, 4'he, 4'h4, 4'h7, 4'hb, 4'hd, 4'h0, 4'hf},
    '{4'hc, 4'h4, 4'h6, 4'h2, 4'ha, 4'h5, 4'hb, 4'h9,
      4'he, 4'h8, 4'hd, 4'h7, 4'h0, 4'h3, 4'hf, 4'h1}
  };

  function automatic word_t mix(input word_t half, input word_t k);
    word_t s;
    word_t t;
    s = half + k;
    for (int j = 0; j < 8; j++) begin
      t[WordW-4-4*j +: 4] = SBOX[j][s[WordW-4-4*j +: 4]];
    end
    return {t[WordW-RotAmt-1:0], t[WordW-1:WordW-RotAmt]};
  endfunction

  function automatic logic [2:0] key_sel(input int unsigned round);
    logic [2:0] low;
    low = round[2:0];
    return (round < FwdRounds) ? low : (WordMask - low);
  endfunction

endpackage

### rtl/core/mbc_round.sv
// One registered Feistel round of the Magma pipeline.
// Depends on mbc_pkg (types, round function, key word selection).
module mbc_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbc_pkg::stage_ctl_t ctl_in,
  input  mbc_pkg::word_t      left_in,
  input  mbc_pkg::word_t      right_in,
  input  mbc_pkg::key_sched_t keys,
  output mbc_pkg::stage_ctl_t ctl_out,
  output mbc_pkg::word_t      left_out,
  output mbc_pkg::word_t      right_out
);
  import mbc_pkg::*;

  localparam logic [2:0] EncSel = key_sel(RoundIdx);
  localparam logic [2:0] DecSel = key_sel(NumRounds - 1 - RoundIdx);
  localparam bit         LastRound = (RoundIdx == NumRounds - 1);

  stage_ctl_t ctl_r, ctl_nxt;
  word_t      left_r, left_nxt;
  word_t      right_r, right_nxt;
  word_t      rkey;
  word_t      mixed;

  always_comb begin
    rkey    = (ctl_in.kind == KindDecrypt) ? keys[DecSel] : keys[EncSel];
    mixed   = left_in ^ mix(right_in, rkey);
    ctl_nxt = ctl_in;
    if (LastRound) begin
      left_nxt  = mixed;
      right_nxt = right_in;
    end else begin
      left_nxt  = right_in;
      right_nxt = mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign ctl_out   = ctl_r;
  assign left_out  = left_r;
  assign right_out = right_r;

endmodule

### rtl/core/magma_block_cipher_64.sv
// Top level of the Magma 64-bit block cipher: key registers and a
// 32-stage round pipeline. Depends on mbc_pkg and mbc_round.
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+--------------------------
//   input   | in_kind, in_block_in                | start high, busy low
//   result  | out_block_out                       | out_valid strobe, 1 cycle
//   config  | cfg_index, cfg_data                 | cfg_valid and cfg_ready
//
// One round per stage: a transaction passes through every stage register from start to out_valid,
// and a new block is taken every cycle. busy stays low and cfg_ready high.
// Synchronous active-low reset clears stage valid bits and the key to zero.
// Results cannot be held off, so the pipeline never stalls.
module magma_block_cipher_64 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [mbc_pkg::BlockW-1:0]   in_block_in,
  output logic                         out_valid,
  output logic [mbc_pkg::BlockW-1:0]   out_block_out,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mbc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mbc_pkg::BlockW-1:0]   cfg_data
);
  import mbc_pkg::*;

  logic [BlockW-1:0] key_r [NumKeyRegs];
  key_sched_t        keys;
  stage_ctl_t        ctl [NumRounds+1];
  word_t             lh  [NumRounds+1];
  word_t             rh  [NumRounds+1];
  logic              cfg_wr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready && (cfg_index < CfgIdxW'(NumKeyRegs));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumKeyRegs; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      key_r[cfg_index[1:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NumKeyRegs; i++) begin
      keys[2*i]   = key_r[i][BlockW-1:WordW];
      keys[2*i+1] = key_r[i][WordW-1:0];
    end
  end

  assign ctl[0].valid = start && !busy;
  assign ctl[0].kind  = in_kind;
  assign lh[0]        = in_block_in[BlockW-1:WordW];
  assign rh[0]        = in_block_in[WordW-1:0];

  for (genvar n = 0; n < NumRounds; n++) begin : g_round
    mbc_round #(
      .RoundIdx(n)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_in   (ctl[n]),
      .left_in  (lh[n]),
      .right_in (rh[n]),
      .keys     (keys),
      .ctl_out  (ctl[n+1]),
      .left_out (lh[n+1]),
      .right_out(rh[n+1])
    );
  end

  assign out_valid     = ctl[NumRounds].valid;
  assign out_block_out = {lh[NumRounds], rh[NumRounds]};

endmodule
